// File: rtl/core/sqr_pkg.sv
// Shared types, constants and helper functions of the sprite quad corner pipeline.
// Used by sqr_cordic, sqr_div and sprite_quad_rotate_to_ndc; depends on nothing.
`default_nettype none

package sqr_pkg;

	// One sprite draw request.
	typedef struct packed {
		logic signed [15:0] dest_x;
		logic signed [15:0] dest_y;
		logic signed [15:0] dest_w;
		logic signed [15:0] dest_h;
		logic signed [15:0] src_x;
		logic signed [15:0] src_y;
		logic signed [15:0] src_w;
		logic signed [15:0] src_h;
		logic signed [15:0] angle_deg;
	} sprite_t;

	// One corner of the quad.
	typedef struct packed {
		logic [1:0]         corner;
		logic signed [15:0] ndc_x;
		logic signed [15:0] ndc_y;
		logic signed [15:0] tex_u;
		logic signed [15:0] tex_v;
		logic               last;
	} vert_t;

	// Corner identity that travels alongside the arithmetic.
	typedef struct packed {
		logic [1:0] corner;
		logic       last;
	} tag_t;

	// Corner geometry that rides through the sine/cosine pipeline.
	typedef struct packed {
		tag_t               tag;
		logic signed [17:0] cx;   // 2*dest_x + dest_w, Q.5 centre
		logic signed [17:0] cy;
		logic signed [16:0] ox;   // offset from the centre, Q.5
		logic signed [16:0] oy;
		logic signed [16:0] su;   // source corner, Q.4
		logic signed [16:0] sv;
	} geom_t;

	typedef enum logic [1:0] {
		REG_SCREEN_W  = 2'd0,
		REG_SCREEN_H  = 2'd1,
		REG_TEXTURE_W = 2'd2,
		REG_TEXTURE_H = 2'd3
	} reg_idx_t;

	localparam logic [1:0] CORNER_LAST = 2'd3;

	localparam int CORDIC_ITERS = 16;
	localparam int CORDIC_LAT   = CORDIC_ITERS + 2;
	localparam int QUO_BITS     = 17;
	localparam int DIV_LAT      = QUO_BITS + 1;
	localparam int NUM_W        = 36;
	localparam int DEN_W        = 19;

	localparam logic signed [33:0] CORDIC_K = 34'sd652032874;

	// Rounded atan(2^-i) in degrees, Q.16.
	localparam logic signed [24:0] ATAN_Q16 [CORDIC_ITERS] = '{
		25'sd2949120, 25'sd1740967, 25'sd919879, 25'sd466945,
		25'sd234379,  25'sd117304,  25'sd58666,  25'sd29335,
		25'sd14668,   25'sd7334,    25'sd3667,   25'sd1833,
		25'sd917,     25'sd458,     25'sd229,    25'sd115
	};

	function automatic logic [13:0] nonzero14(input logic [13:0] v);
		nonzero14 = (v == 14'd0) ? 14'd1 : v;
	endfunction

	function automatic logic signed [15:0] sat16(input logic signed [18:0] v);
		if (v > 19'sd32767) begin
			sat16 = 16'sh7fff;
		end else if (v < -19'sd32768) begin
			sat16 = -16'sh8000;
		end else begin
			sat16 = v[15:0];
		end
	endfunction

endpackage

`default_nettype wire

// File: rtl/core/sprite_quad_rotate_to_ndc.sv
// Top level of the sprite quad corner generator: corner sequencer, rotation products,
// NDC/texture numerators, four dividers and the output register. Uses sqr_pkg,
// sqr_cordic and sqr_div.
//
// Usage. A sprite beat on the sprite channel (sprite_valid high, sprite_stall low)
// carries one draw request. The block answers with four beats on the vert channel,
// one per corner in the order top-left, top-right, bottom-left, bottom-right; the
// fourth has last set. Each corner is rotated about the rectangle centre, mapped
// to NDC through the screen size registers and given texture coordinates scaled
// by the texture size registers, all outputs saturated to 16 bits.
// Throughput: one vert beat per cycle while sprites keep coming and vert_stall is low.
// The corner sequencer feeds one corner per enabled cycle into a single shared
// pipeline and takes the next sprite while the last corner of the current one goes in.
// Path: the sequencer register is loaded at the accepting edge itself; each
// corner then passes the sine/cosine pipeline (angle reduction, 16 CORDIC
// iterations, rounding), the product register, the numerator register, the
// dividers and the output register.
// Stall: the whole pipeline advances together; while vert_stall holds a valid
// beat, every stage keeps its contents and sprite_stall rises once the sequencer
// holds a request.
// Reset: arst_n clears all valid bits and loads a 1280x720 screen and 256x256
// texture; a size of zero acts as one. The user writes registers through cfg_we,
// cfg_index and cfg_data only while the block is idle; the block does not check.
`default_nettype none

module sprite_quad_rotate_to_ndc
	import sqr_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        sprite_valid,
	output logic             sprite_stall,
	input  wire sprite_t     sprite,
	output logic             vert_valid,
	input  wire logic        vert_stall,
	output vert_t            vert,
	input  wire logic        cfg_we,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [13:0] cfg_data
);

	localparam int VLD_LEN = CORDIC_LAT + 2 + DIV_LAT;

	logic [13:0] screen_w_q, screen_h_q, texture_w_q, texture_h_q;
	logic [13:0] sw_nz, sh_nz, tw_nz, th_nz;

	logic       en;
	logic       accept;
	sprite_t    hold_q;
	logic       hold_valid_q;
	logic [1:0] cnt_q;

	geom_t geom_in, geom_c;
	logic signed [15:0] cos_c, sin_c;

	logic [VLD_LEN-1:0] vld_s;

	logic signed [32:0] pcx_s1, psy_s1, psx_s1, pcy_s1;
	logic signed [17:0] cx_s1, cy_s1;
	logic signed [16:0] su_s1, sv_s1;
	tag_t               tag_s1;

	logic signed [NUM_W-1:0] nx_s2, ny_s2, nu_s2, nv_s2;
	tag_t                    tag_s2;

	tag_t tag_d [DIV_LAT];

	logic [DEN_W-1:0] den_x, den_y, den_u, den_v;
	logic signed [QUO_BITS:0] qx, qy, qu, qv;

	vert_t vert_q;
	logic  vert_valid_q;

	// Register file. Writes to any index always land on one of the four.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			screen_w_q  <= 14'd1280;
			screen_h_q  <= 14'd720;
			texture_w_q <= 14'd256;
			texture_h_q <= 14'd256;
		end else if (cfg_we) begin
			case (reg_idx_t'(cfg_index))
				REG_SCREEN_W:  screen_w_q  <= cfg_data;
				REG_SCREEN_H:  screen_h_q  <= cfg_data;
				REG_TEXTURE_W: texture_w_q <= cfg_data;
				REG_TEXTURE_H: texture_h_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign sw_nz = nonzero14(screen_w_q);
	assign sh_nz = nonzero14(screen_h_q);
	assign tw_nz = nonzero14(texture_w_q);
	assign th_nz = nonzero14(texture_h_q);

	// The pipeline moves whenever the output register is free or being emptied.
	assign en = !vert_valid_q || !vert_stall;

	// Corner sequencer: holds one request and emits its four corners on
	// consecutive enabled cycles. A new request is taken on the last one or when empty.
	assign sprite_stall = hold_valid_q && !(en && cnt_q == CORNER_LAST);
	assign accept       = sprite_valid && !sprite_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_valid_q <= 1'b0;
			cnt_q        <= '0;
		end else begin
			if (en && hold_valid_q) begin
				cnt_q <= cnt_q + 2'd1;
				if (cnt_q == CORNER_LAST) begin
					hold_valid_q <= 1'b0;
				end
			end
			if (accept) begin
				hold_valid_q <= 1'b1;
				cnt_q        <= '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			hold_q <= sprite;
		end
	end

	// Geometry of the current corner. Bit 0 selects the right edge, bit 1 the bottom.
	always_comb begin
		geom_in.tag.corner = cnt_q;
		geom_in.tag.last   = (cnt_q == CORNER_LAST);
		geom_in.cx = (18'(hold_q.dest_x) <<< 1) + 18'(hold_q.dest_w);
		geom_in.cy = (18'(hold_q.dest_y) <<< 1) + 18'(hold_q.dest_h);
		geom_in.ox = cnt_q[0] ? 17'(hold_q.dest_w) : -17'(hold_q.dest_w);
		geom_in.oy = cnt_q[1] ? 17'(hold_q.dest_h) : -17'(hold_q.dest_h);
		geom_in.su = cnt_q[0] ? 17'(hold_q.src_x) + 17'(hold_q.src_w) : 17'(hold_q.src_x);
		geom_in.sv = cnt_q[1] ? 17'(hold_q.src_y) + 17'(hold_q.src_h) : 17'(hold_q.src_y);
	end

	sqr_cordic u_cordic (
		.clk      (clk),
		.en       (en),
		.angle    (hold_q.angle_deg),
		.geom_in  (geom_in),
		.cos_out  (cos_c),
		.sin_out  (sin_c),
		.geom_out (geom_c)
	);

	// Valid bits for every stage after the sequencer up to the last divider stage.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (en) begin
			vld_s <= {vld_s[VLD_LEN-2:0], hold_valid_q};
		end
	end

	// Rotation products.
	always_ff @(posedge clk) begin
		if (en) begin
			pcx_s1 <= 33'(cos_c) * 33'(geom_c.ox);
			psy_s1 <= 33'(sin_c) * 33'(geom_c.oy);
			psx_s1 <= 33'(sin_c) * 33'(geom_c.ox);
			pcy_s1 <= 33'(cos_c) * 33'(geom_c.oy);
			cx_s1  <= geom_c.cx;
			cy_s1  <= geom_c.cy;
			su_s1  <= geom_c.su;
			sv_s1  <= geom_c.sv;
			tag_s1 <= geom_c.tag;
		end
	end

	// Numerators for round-half-up division: floor((2n + d) / 2d).
	always_ff @(posedge clk) begin
		if (en) begin
			nx_s2 <= (NUM_W'(cx_s1) <<< 15) + (NUM_W'(pcx_s1) <<< 1)
				- (NUM_W'(psy_s1) <<< 1) + $signed({18'd0, sw_nz, 4'd0});
			ny_s2 <= (NUM_W'(cy_s1) <<< 15) + (NUM_W'(psx_s1) <<< 1)
				+ (NUM_W'(pcy_s1) <<< 1) + $signed({18'd0, sh_nz, 4'd0});
			nu_s2 <= (NUM_W'(su_s1) <<< 9) + $signed({22'd0, tw_nz});
			nv_s2 <= (NUM_W'(sv_s1) <<< 9) + $signed({22'd0, th_nz});
			tag_s2 <= tag_s1;
		end
	end

	assign den_x = {sw_nz, 5'd0};
	assign den_y = {sh_nz, 5'd0};
	assign den_u = {4'd0, tw_nz, 1'b0};
	assign den_v = {4'd0, th_nz, 1'b0};

	sqr_div u_div_x (.clk(clk), .en(en), .num(nx_s2), .den(den_x), .quo(qx));
	sqr_div u_div_y (.clk(clk), .en(en), .num(ny_s2), .den(den_y), .quo(qy));
	sqr_div u_div_u (.clk(clk), .en(en), .num(nu_s2), .den(den_u), .quo(qu));
	sqr_div u_div_v (.clk(clk), .en(en), .num(nv_s2), .den(den_v), .quo(qv));

	// Corner tags follow the dividers.
	always_ff @(posedge clk) begin
		if (en) begin
			tag_d[0] <= tag_s2;
			for (int i = 1; i < DIV_LAT; i++) begin
				tag_d[i] <= tag_d[i-1];
			end
		end
	end

	// Output register with the NDC offsets and saturation.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vert_valid_q <= 1'b0;
		end else if (en) begin
			vert_valid_q <= vld_s[VLD_LEN-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			vert_q.corner <= tag_d[DIV_LAT-1].corner;
			vert_q.last   <= tag_d[DIV_LAT-1].last;
			vert_q.ndc_x  <= sat16(19'(qx) - 19'sd16384);
			vert_q.ndc_y  <= sat16(19'sd16384 - 19'(qy));
			vert_q.tex_u  <= sat16(19'(qu));
			vert_q.tex_v  <= sat16(19'(qv));
		end
	end

	assign vert_valid = vert_valid_q;
	assign vert       = vert_q;

endmodule

`default_nettype wire

// File: rtl/core/sqr_cordic.sv
// Pipelined sine/cosine: angle reduction, one CORDIC iteration per stage, Q1.14 rounding.
// Carries the corner geometry alongside; uses sqr_pkg.
`default_nettype none

module sqr_cordic
	import sqr_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               en,
	input  wire logic signed [15:0] angle,
	input  wire geom_t              geom_in,
	output logic signed [15:0]      cos_out,
	output logic signed [15:0]      sin_out,
	output geom_t                   geom_out
);

	logic signed [17:0] a_ext, r0, r1, r2;
	logic               fold;

	logic signed [24:0] z_s1;
	logic               neg_s1;
	geom_t              geom_s1;

	logic signed [33:0] x_s [CORDIC_ITERS];
	logic signed [33:0] y_s [CORDIC_ITERS];
	logic signed [24:0] z_s [CORDIC_ITERS];
	logic               neg_s [CORDIC_ITERS];
	geom_t              geom_s [CORDIC_ITERS];

	logic signed [33:0] vx, vy;
	logic signed [17:0] rx, ry;

	// Reduce into (-180, 180], then fold into [-90, 90] with a sign flip.
	always_comb begin
		a_ext = 18'(angle);
		if (a_ext < -18'sd23040) begin
			r0 = a_ext + 18'sd46080;
		end else if (a_ext < 18'sd0) begin
			r0 = a_ext + 18'sd23040;
		end else if (a_ext >= 18'sd23040) begin
			r0 = a_ext - 18'sd23040;
		end else begin
			r0 = a_ext;
		end
		r1 = (r0 > 18'sd11520) ? r0 - 18'sd23040 : r0;
		fold = 1'b0;
		r2 = r1;
		if (r1 > 18'sd5760) begin
			r2 = r1 - 18'sd11520;
			fold = 1'b1;
		end else if (r1 < -18'sd5760) begin
			r2 = r1 + 18'sd11520;
			fold = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			z_s1    <= 25'(r2) <<< 10;
			neg_s1  <= fold;
			geom_s1 <= geom_in;
		end
	end

	for (genvar i = 0; i < CORDIC_ITERS; i++) begin : g_iter
		logic signed [33:0] xi, yi;
		logic signed [24:0] zi;
		logic               ni;
		geom_t              gi;

		if (i == 0) begin : g_first
			assign xi = CORDIC_K;
			assign yi = '0;
			assign zi = z_s1;
			assign ni = neg_s1;
			assign gi = geom_s1;
		end else begin : g_next
			assign xi = x_s[i-1];
			assign yi = y_s[i-1];
			assign zi = z_s[i-1];
			assign ni = neg_s[i-1];
			assign gi = geom_s[i-1];
		end

		always_ff @(posedge clk) begin
			if (en) begin
				if (zi >= 25'sd0) begin
					x_s[i] <= xi - (yi >>> i);
					y_s[i] <= yi + (xi >>> i);
					z_s[i] <= zi - ATAN_Q16[i];
				end else begin
					x_s[i] <= xi + (yi >>> i);
					y_s[i] <= yi - (xi >>> i);
					z_s[i] <= zi + ATAN_Q16[i];
				end
				neg_s[i]  <= ni;
				geom_s[i] <= gi;
			end
		end
	end

	// Round half up to Q1.14 and clamp to plus or minus one.
	always_comb begin
		vx = neg_s[CORDIC_ITERS-1] ? -x_s[CORDIC_ITERS-1] : x_s[CORDIC_ITERS-1];
		vy = neg_s[CORDIC_ITERS-1] ? -y_s[CORDIC_ITERS-1] : y_s[CORDIC_ITERS-1];
		rx = 18'((vx + 34'sd32768) >>> 16);
		ry = 18'((vy + 34'sd32768) >>> 16);
		if (rx > 18'sd16384) rx = 18'sd16384;
		if (rx < -18'sd16384) rx = -18'sd16384;
		if (ry > 18'sd16384) ry = 18'sd16384;
		if (ry < -18'sd16384) ry = -18'sd16384;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			cos_out  <= rx[15:0];
			sin_out  <= ry[15:0];
			geom_out <= geom_s[CORDIC_ITERS-1];
		end
	end

endmodule

`default_nettype wire

// File: rtl/core/sqr_div.sv
// Pipelined floor division of a signed numerator by a positive divisor, one quotient bit
// per stage, quotient clamped to QUO_BITS of magnitude. Uses sqr_pkg.
`default_nettype none

module sqr_div
	import sqr_pkg::*;
(
	input  wire logic                    clk,
	input  wire logic                    en,
	input  wire logic signed [NUM_W-1:0] num,
	input  wire logic [DEN_W-1:0]        den,
	output logic signed [QUO_BITS:0]     quo
);

	logic [NUM_W-1:0]    rem_s [DIV_LAT];
	logic [QUO_BITS-1:0] quo_s [DIV_LAT];
	logic                neg_s [DIV_LAT];
	logic                ovf_s [DIV_LAT];

	logic [NUM_W-1:0] mag, den_top;
	logic [QUO_BITS-1:0] qq;

	// For a negative numerator, floor(n/d) = ~floor(~n/d).
	always_comb begin
		mag     = num[NUM_W-1] ? ~num : num;
		den_top = NUM_W'(den) << QUO_BITS;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem_s[0] <= mag;
			quo_s[0] <= '0;
			neg_s[0] <= num[NUM_W-1];
			ovf_s[0] <= (mag >= den_top);
		end
	end

	for (genvar k = 1; k < DIV_LAT; k++) begin : g_bit
		localparam int B = QUO_BITS - k;
		logic [NUM_W-1:0] dsh;
		logic             take;

		assign dsh  = NUM_W'(den) << B;
		assign take = (rem_s[k-1] >= dsh);

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k] <= take ? rem_s[k-1] - dsh : rem_s[k-1];
				quo_s[k] <= quo_s[k-1] | (QUO_BITS'(take) << B);
				neg_s[k] <= neg_s[k-1];
				ovf_s[k] <= ovf_s[k-1];
			end
		end
	end

	always_comb begin
		qq  = ovf_s[DIV_LAT-1] ? '1 : quo_s[DIV_LAT-1];
		quo = neg_s[DIV_LAT-1] ? ~{1'b0, qq} : {1'b0, qq};
	end

endmodule

`default_nettype wire

// File: bench/tb.sv
// Self-checking bench for sprite_quad_rotate_to_ndc: drives sprite beats, predicts the
// four corner beats of each sprite and checks them in order. Depends on sqr_pkg and
// the RTL of the block only.
`default_nettype none

module tb;
	import sqr_pkg::*;

	// Keeps the expected corner beats and the register copy the prediction uses.
	class quad_scoreboard;
		logic [13:0] regs [4];
		vert_t       corner_q [$];

		function new();
			regs[REG_SCREEN_W]  = 14'd1280;
			regs[REG_SCREEN_H]  = 14'd720;
			regs[REG_TEXTURE_W] = 14'd256;
			regs[REG_TEXTURE_H] = 14'd256;
		endfunction

		function longint floor_div(longint n, longint d);
			longint q;
			q = n / d;
			if ((n % d) != 0 && n < 0) begin
				q = q - 1;
			end
			return q;
		endfunction

		// Nearest, ties toward plus infinity; d is always positive.
		function longint round_div(longint n, longint d);
			return floor_div(2 * n + d, 2 * d);
		endfunction

		function logic [15:0] clip16(longint v);
			if (v > 32767) begin
				return 16'h7fff;
			end else if (v < -32768) begin
				return 16'h8000;
			end
			return v[15:0];
		endfunction

		function longint size_of(logic [13:0] r);
			return (r == 14'd0) ? 64'sd1 : longint'({50'd0, r});
		endfunction

		function longint to_q14(longint v);
			longint r;
			r = (v + 32768) >>> 16;
			if (r > 16384) begin
				r = 16384;
			end else if (r < -16384) begin
				r = -16384;
			end
			return r;
		endfunction

		// Angle reduction to +-90 degrees, then 16 CORDIC rotations in Q2.30.
		function void sin_cos(longint a, output longint c, output longint s);
			longint r, x, y, z, nx;
			bit     flip;
			r = a % 23040;
			flip = 0;
			x = 652032874;
			y = 0;
			if (r < 0) begin
				r = r + 23040;
			end
			if (r > 11520) begin
				r = r - 23040;
			end
			if (r > 5760) begin
				r = r - 11520;
				flip = 1;
			end else if (r < -5760) begin
				r = r + 11520;
				flip = 1;
			end
			z = r * 1024;
			for (int i = 0; i < CORDIC_ITERS; i++) begin
				if (z >= 0) begin
					nx = x - (y >>> i);
					y = y + (x >>> i);
					z = z - longint'(ATAN_Q16[i]);
				end else begin
					nx = x + (y >>> i);
					y = y - (x >>> i);
					z = z + longint'(ATAN_Q16[i]);
				end
				x = nx;
			end
			c = to_q14(flip ? -x : x);
			s = to_q14(flip ? -y : y);
		endfunction

		// Called for every accepted sprite beat: queues its four corners.
		function void note_sprite(sprite_t sp);
			longint dx, dy, dw, dh, sx, sy, sw, sh, c, s, cx, cy, ox, oy, px, py, su, sv;
			vert_t  v;
			dx = sp.dest_x;
			dy = sp.dest_y;
			dw = sp.dest_w;
			dh = sp.dest_h;
			sx = sp.src_x;
			sy = sp.src_y;
			sw = sp.src_w;
			sh = sp.src_h;
			sin_cos(longint'(sp.angle_deg), c, s);
			cx = (2 * dx + dw) * 16384;
			cy = (2 * dy + dh) * 16384;
			for (int k = 0; k < 4; k++) begin
				ox = k[0] ? dw : -dw;
				oy = k[1] ? dh : -dh;
				px = cx + c * ox - s * oy;
				py = cy + s * ox + c * oy;
				su = k[0] ? sx + sw : sx;
				sv = k[1] ? sy + sh : sy;
				v.corner = k[1:0];
				v.ndc_x = clip16(round_div(px, 16 * size_of(regs[REG_SCREEN_W])) - 16384);
				v.ndc_y = clip16(16384 - round_div(py, 16 * size_of(regs[REG_SCREEN_H])));
				v.tex_u = clip16(round_div(su * 256, size_of(regs[REG_TEXTURE_W])));
				v.tex_v = clip16(round_div(sv * 256, size_of(regs[REG_TEXTURE_H])));
				v.last = (k[1:0] == CORNER_LAST);
				corner_q.push_back(v);
			end
		endfunction

		// Returns the names of the fields that differ, empty when the beat matches, or unexpected when none is queued.
		function string check_corner(vert_t got, output vert_t want);
			string bad;
			bad = "";
			if (corner_q.size() == 0) begin
				want = '0;
				return "unexpected";
			end
			want = corner_q.pop_front();
			if (got.corner !== want.corner) bad = {bad, " corner"};
			if (got.ndc_x !== want.ndc_x) bad = {bad, " ndc_x"};
			if (got.ndc_y !== want.ndc_y) bad = {bad, " ndc_y"};
			if (got.tex_u !== want.tex_u) bad = {bad, " tex_u"};
			if (got.tex_v !== want.tex_v) bad = {bad, " tex_v"};
			if (got.last !== want.last) bad = {bad, " last"};
			return bad;
		endfunction

		function int pending();
			return corner_q.size();
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        sprite_valid = 1'b0;
	logic        sprite_stall;
	sprite_t     sprite = '0;
	logic        vert_valid;
	logic        vert_stall = 1'b0;
	vert_t       vert;
	logic        cfg_we = 1'b0;
	logic [1:0]  cfg_index = 2'd0;
	logic [13:0] cfg_data = 14'd0;

	quad_scoreboard sb = new();
	int  errors = 0;
	bit  long_hold_req = 0;
	int  burst_left = 0;

	sprite_quad_rotate_to_ndc u_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.sprite_valid(sprite_valid),
		.sprite_stall(sprite_stall),
		.sprite      (sprite),
		.vert_valid  (vert_valid),
		.vert_stall  (vert_stall),
		.vert        (vert),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// The whole run, stalls included, needs far fewer cycles than this.
	initial begin
		#3000000;
		$display("DONE: errors detected");
		$finish;
	end

	task automatic report(string what, vert_t got, vert_t want);
		$display("MISMATCH%s: got %h expected %h", what, got, want);
		errors++;
	endtask

	// Output side. Every beat taken at an edge is checked against the oldest
	// expectation. The stall pattern switches among random duties, and on
	// request the receiver holds off for a long stretch so the pipeline fills
	// and the sprite channel stalls back.
	initial begin
		int    hold_cnt;
		int    duty;
		int    cyc;
		string bad;
		vert_t want;
		hold_cnt = 0;
		duty = 0;
		cyc = 0;
		forever begin
			@(posedge clk);
			if (vert_valid && !vert_stall) begin
				bad = sb.check_corner(vert, want);
				if (bad != "") begin
					report(bad, vert, want);
				end
			end
			cyc++;
			if (cyc % 64 == 0) begin
				case ($urandom_range(0, 3))
					0: duty = 0;
					1: duty = 20;
					2: duty = 50;
					default: duty = 85;
				endcase
			end
			if (long_hold_req) begin
				long_hold_req = 0;
				hold_cnt = 400;
			end
			if (hold_cnt > 0) begin
				hold_cnt--;
				vert_stall <= 1'b1;
			end else begin
				vert_stall <= ($urandom_range(0, 99) < duty);
			end
		end
	end

	// Register write: one cycle with cfg_we high. The prediction uses the new
	// value for every sprite accepted afterwards. The caller drops cfg_we.
	task automatic write_reg(reg_idx_t idx, logic [13:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		sb.regs[idx] = val;
	endtask

	// Waits until every expected corner has come, then lets the pipeline drain.
	task automatic drain();
		while (sb.pending() != 0) begin
			@(posedge clk);
		end
		repeat (45) @(posedge clk);
	endtask

	task automatic set_sizes(logic [13:0] sw, logic [13:0] sh, logic [13:0] tw,
			logic [13:0] th);
		drain();
		write_reg(REG_SCREEN_W, sw);
		write_reg(REG_SCREEN_H, sh);
		write_reg(REG_TEXTURE_W, tw);
		write_reg(REG_TEXTURE_H, th);
		cfg_we <= 1'b0;
	endtask

	// Offers one sprite beat and holds it until taken. Between beats the
	// sender idles in random gaps at the end of each burst.
	task automatic send_sprite(sprite_t sp);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 12);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
			if (gap > 0) begin
				sprite_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		sprite_valid <= 1'b1;
		sprite <= sp;
		do begin
			@(posedge clk);
		end while (sprite_stall);
		sb.note_sprite(sp);
	endtask

	function automatic sprite_t make_sprite(int dx, int dy, int dw, int dh, int sx, int sy,
			int sw, int sh, int ang);
		sprite_t sp;
		sp.dest_x = dx[15:0];
		sp.dest_y = dy[15:0];
		sp.dest_w = dw[15:0];
		sp.dest_h = dh[15:0];
		sp.src_x = sx[15:0];
		sp.src_y = sy[15:0];
		sp.src_w = sw[15:0];
		sp.src_h = sh[15:0];
		sp.angle_deg = ang[15:0];
		return sp;
	endfunction

	// Mostly on-screen sprites with sane sizes and angles anywhere in the
	// 16-bit range; the rest are raw random words.
	function automatic sprite_t rand_sprite();
		sprite_t sp;
		if ($urandom_range(0, 9) < 7) begin
			sp = make_sprite($urandom_range(0, 20480), $urandom_range(0, 11520),
				$urandom_range(0, 2048) - 512, $urandom_range(0, 2048) - 512,
				$urandom_range(0, 4096), $urandom_range(0, 4096),
				$urandom_range(0, 2048) - 512, $urandom_range(0, 2048) - 512,
				$urandom_range(0, 46080) - 23040);
			if ($urandom_range(0, 3) == 0) begin
				sp.angle_deg = 16'($urandom());
			end
		end else begin
			sp = 144'({$urandom(), $urandom(), $urandom(), $urandom(), $urandom()});
		end
		return sp;
	endfunction

	task automatic random_phase(int count, bit with_hold, bit with_pause);
		for (int i = 0; i < count; i++) begin
			if (with_hold && i == 5) begin
				long_hold_req = 1;
			end
			if (with_pause && i == count / 2) begin
				// Sender stands back until every expected corner is out.
				sprite_valid <= 1'b0;
				burst_left = 0;
				@(posedge clk);
				while (sb.pending() != 0) begin
					@(posedge clk);
				end
			end
			send_sprite(rand_sprite());
		end
		sprite_valid <= 1'b0;
		burst_left = 0;
		@(posedge clk);
	endtask

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed sprites under the reset sizes: field extremes, the quadrant
		// boundaries of the angle, wrap of out-of-range angles, mirrored
		// quads from negative sizes and rounding ties.
		send_sprite(make_sprite(0, 0, 0, 0, 0, 0, 0, 0, 0));
		send_sprite(make_sprite(32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767,
			32767));
		send_sprite(make_sprite(-32768, -32768, -32768, -32768, -32768, -32768, -32768,
			-32768, -32768));
		send_sprite(make_sprite(-1, -1, -1, -1, -1, -1, -1, -1, -1));
		send_sprite(make_sprite(10240, 5760, 1600, 800, 256, 512, 1024, 512, 5760));
		send_sprite(make_sprite(10240, 5760, 1600, 800, 256, 512, 1024, 512, -5760));
		send_sprite(make_sprite(10240, 5760, 1600, 800, 256, 512, 1024, 512, 11520));
		send_sprite(make_sprite(10240, 5760, 1600, 800, 256, 512, 1024, 512, -11520));
		send_sprite(make_sprite(10240, 5760, 1600, 800, 256, 512, 1024, 512, 23040));
		send_sprite(make_sprite(10240, 5760, 1600, 800, 256, 512, 1024, 512, -23040));
		send_sprite(make_sprite(10240, 5760, 1600, 800, 256, 512, 1024, 512, 2880));
		send_sprite(make_sprite(10240, 5760, 1600, 800, 256, 512, 1024, 512, 5761));
		send_sprite(make_sprite(10240, 5760, 1600, 800, 256, 512, 1024, 512, 11521));
		send_sprite(make_sprite(10240, 5760, 1600, 800, 256, 512, 1024, 512, 30000));
		send_sprite(make_sprite(10240, 5760, -1600, -800, 256, 512, -1024, -512, 1000));
		send_sprite(make_sprite(5, 5, 10, 10, 8, 8, 8, 8, 0));
		send_sprite(make_sprite(40, 0, 0, 0, 1, 1, 0, 0, 0));
		send_sprite(make_sprite(0, 0, 1, 1, -2048, -2048, 4096, 4096, 64));
		send_sprite(make_sprite(-32768, 32767, 32767, -32768, 0, 32767, -32768, 32767, 0));
		sprite_valid <= 1'b0;
		burst_left = 0;
		@(posedge clk);

		random_phase(70, 1, 1);
		set_sizes(14'd1, 14'd1, 14'd1, 14'd1);
		random_phase(60, 0, 0);
		set_sizes(14'd8192, 14'd8192, 14'd8192, 14'd8192);
		random_phase(60, 0, 1);
		// Zero sizes act as one; also the largest value the port carries.
		set_sizes(14'd0, 14'd16383, 14'd0, 14'd16383);
		random_phase(50, 1, 0);
		set_sizes(14'($urandom_range(1, 8192)), 14'($urandom_range(1, 8192)),
			14'($urandom_range(1, 8192)), 14'($urandom_range(1, 8192)));
		random_phase(80, 0, 0);
		set_sizes(14'd1920, 14'd1080, 14'd64, 14'd512);
		random_phase(70, 0, 0);

		drain();
		if (errors == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule

`default_nettype wire
